### design/dgrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgrc_pkg: shared definitions for the dependency graph refcount cull unit
// Field widths, command codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package dgrc_pkg;

    // Widths of the word fields on the ports.
    localparam int MODE_W   = 3;
    localparam int NODE_W   = 6;
    localparam int REF_W    = 7;
    localparam int STATUS_W = 3;

    // Reference counts saturate here on increment.
    localparam logic [REF_W-1:0] REF_MAX = 7'd127;

    // Command codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_ADD_NODE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_EDGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TARGET   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CULL     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    // Status codes returned with each result word.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NODE_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EDGE_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_CONFLICT  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TGT_CHK,
        ST_INC_EDGE,
        ST_INC_NODE,
        ST_INC_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_DEC_WR,
        ST_RPT_RD,
        ST_RPT_OUT
    } dgrc_state_t;

endpackage

### design/dependency_graph_refcount_cull_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_graph_refcount_cull_unit: dead-node elimination by refcount
// Loads a node and edge table one command word at a time and culls nodes
// that nothing references, reporting each node's effective count.
// ----------------------------------------------------------------------------
// The unit takes one command word at a time and is stalled until that word
// has been executed. Add node, add edge, clear and unknown codes pass through
// an accept state and an execute state and return one result word; make
// target adds a check state because it reads the node count table first.
// Cull walks the tables with a small sequencer and one read port per table,
// so its length depends on the node, edge and popped-node counts of the graph
// and on stalls of result words on the output side. The read-modify-write of
// one count per edge and the full edge scan for every popped node dominate.
// A cull returns one word per node in id order with last set on the final
// one; a cull with no nodes returns nothing. Reference counts are kept from
// one cull to the next. Every other command returns exactly one word with
// last set. A result word waits in an output register, so the next command
// word can be accepted while the previous result is still stalled.
// No clearing pass is needed after reset: a node's count and pin flag are
// written when the node is added, and only the entries of added nodes are ever used.
// ----------------------------------------------------------------------------
module dependency_graph_refcount_cull_unit #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dgrc_pkg::MODE_W-1:0]     mode,
    input  logic [dgrc_pkg::NODE_W-1:0]     src_node,
    input  logic [dgrc_pkg::NODE_W-1:0]     dst_node,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [dgrc_pkg::NODE_W-1:0]     node_index,
    output logic [dgrc_pkg::REF_W-1:0]      ref_total,
    output logic                            culled,
    output logic [dgrc_pkg::STATUS_W-1:0]   status,
    output logic                            last
);

    // Address widths of the node and edge tables, and widths of the counters
    // that must also hold the full table size.
    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int NODE_CW = $clog2(MAX_NODES + 1);
    localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
    localparam int CMP_W   = dgrc_pkg::NODE_W + 1;

    // Table storage. The count and pin tables share a read address and a write
    // address; so do the source and destination edge tables.
    logic [NODE_AW-1:0]          esrc_mem  [MAX_EDGES];
    logic [NODE_AW-1:0]          edst_mem  [MAX_EDGES];
    logic [dgrc_pkg::REF_W-1:0]  refs_mem  [MAX_NODES];
    logic                        pin_mem   [MAX_NODES];
    logic [NODE_AW-1:0]          stack_mem [MAX_NODES];

    // Registered read data.
    logic [NODE_AW-1:0]          esrc_rd_reg;
    logic [NODE_AW-1:0]          edst_rd_reg;
    logic [dgrc_pkg::REF_W-1:0]  refs_rd_reg;
    logic                        pin_rd_reg;
    logic [NODE_AW-1:0]          stack_rd_reg;

    // Sequencer and bookkeeping registers.
    dgrc_pkg::dgrc_state_t       state_reg, state_next;
    logic [dgrc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [dgrc_pkg::NODE_W-1:0] src_reg, src_next;
    logic [dgrc_pkg::NODE_W-1:0] dst_reg, dst_next;
    logic [NODE_CW-1:0]          node_total_reg, node_total_next;
    logic [EDGE_CW-1:0]          edge_total_reg, edge_total_next;
    logic [NODE_CW-1:0]          sp_reg, sp_next;
    logic [NODE_AW-1:0]          node_ptr_reg, node_ptr_next;
    logic [EDGE_AW-1:0]          edge_ptr_reg, edge_ptr_next;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [dgrc_pkg::NODE_W-1:0]    node_index_reg, node_index_next;
    logic [dgrc_pkg::REF_W-1:0]     ref_total_reg, ref_total_next;
    logic                           culled_reg, culled_next;
    logic [dgrc_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                           last_reg, last_next;

    // Memory port controls.
    logic                        edge_re, edge_we;
    logic                        node_re, refs_we, pin_we;
    logic [NODE_AW-1:0]          node_ra, node_wa;
    logic [dgrc_pkg::REF_W-1:0]  refs_wd;
    logic                        pin_wd;
    logic                        stack_re, stack_we;
    logic [NODE_AW-1:0]          stack_wd;

    // Helper terms.
    logic                        out_free;
    logic                        out_load;
    logic                        src_bad, dst_bad;
    logic                        last_node, last_edge;
    logic [NODE_CW-1:0]          sp_dec;
    logic [dgrc_pkg::REF_W-1:0]  eff_count;

    assign out_free  = !out_valid_reg || !out_stall;
    assign src_bad   = CMP_W'(src_reg) >= CMP_W'(node_total_reg);
    assign dst_bad   = CMP_W'(dst_reg) >= CMP_W'(node_total_reg);
    assign last_node = (NODE_CW'(node_ptr_reg) + NODE_CW'(1)) == node_total_reg;
    assign last_edge = (EDGE_CW'(edge_ptr_reg) + EDGE_CW'(1)) == edge_total_reg;
    assign sp_dec    = sp_reg - NODE_CW'(1);
    assign eff_count = pin_rd_reg ? dgrc_pkg::REF_W'(1) : refs_rd_reg;

    // ------------------------------------------------------------------
    // Table memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            esrc_mem[edge_total_reg[EDGE_AW-1:0]] <= src_reg[NODE_AW-1:0];
            edst_mem[edge_total_reg[EDGE_AW-1:0]] <= dst_reg[NODE_AW-1:0];
        end
        if (edge_re)
        begin
            esrc_rd_reg <= esrc_mem[edge_ptr_reg];
            edst_rd_reg <= edst_mem[edge_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (refs_we)
        begin
            refs_mem[node_wa] <= refs_wd;
        end
        if (pin_we)
        begin
            pin_mem[node_wa] <= pin_wd;
        end
        if (node_re)
        begin
            refs_rd_reg <= refs_mem[node_ra];
            pin_rd_reg  <= pin_mem[node_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[sp_reg[NODE_AW-1:0]] <= stack_wd;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[sp_dec[NODE_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dgrc_pkg::ST_IDLE;
            node_total_reg <= '0;
            edge_total_reg <= '0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_total_reg <= node_total_next;
            edge_total_reg <= edge_total_next;
            sp_reg         <= sp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        node_ptr_reg   <= node_ptr_next;
        edge_ptr_reg   <= edge_ptr_next;
        node_index_reg <= node_index_next;
        ref_total_reg  <= ref_total_next;
        culled_reg     <= culled_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    // ------------------------------------------------------------------
    // Next state, memory controls and result words
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        node_total_next = node_total_reg;
        edge_total_next = edge_total_reg;
        sp_next         = sp_reg;
        node_ptr_next   = node_ptr_reg;
        edge_ptr_next   = edge_ptr_reg;

        edge_re  = 1'b0;
        edge_we  = 1'b0;
        node_re  = 1'b0;
        node_ra  = node_ptr_reg;
        refs_we  = 1'b0;
        pin_we   = 1'b0;
        node_wa  = esrc_rd_reg;
        refs_wd  = '0;
        pin_wd   = 1'b0;
        stack_re = 1'b0;
        stack_we = 1'b0;
        stack_wd = node_ptr_reg;

        // A result word defaults to all zero with last set; cull, add node and error statuses override.
        out_load        = 1'b0;
        node_index_next = '0;
        ref_total_next  = '0;
        culled_next     = 1'b0;
        status_next     = dgrc_pkg::STATUS_OK;
        last_next       = 1'b1;

        case (state_reg)
            dgrc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    src_next   = src_node;
                    dst_next   = dst_node;
                    state_next = dgrc_pkg::ST_EXEC;
                end
            end

            dgrc_pkg::ST_EXEC:
            begin
                case (mode_reg)
                    dgrc_pkg::MODE_ADD_NODE:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = dgrc_pkg::ST_IDLE;
                            if (node_total_reg == NODE_CW'(MAX_NODES))
                            begin
                                status_next = dgrc_pkg::STATUS_NODE_FULL;
                            end
                            else
                            begin
                                // A new node starts unreferenced and unpinned.
                                node_wa         = node_total_reg[NODE_AW-1:0];
                                refs_we         = 1'b1;
                                pin_we          = 1'b1;
                                node_index_next = dgrc_pkg::NODE_W'(node_total_reg);
                                node_total_next = node_total_reg + NODE_CW'(1);
                            end
                        end
                    end

                    dgrc_pkg::MODE_ADD_EDGE:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = dgrc_pkg::ST_IDLE;
                            if (src_bad || dst_bad)
                            begin
                                status_next = dgrc_pkg::STATUS_BAD_INDEX;
                            end
                            else if (edge_total_reg == EDGE_CW'(MAX_EDGES))
                            begin
                                status_next = dgrc_pkg::STATUS_EDGE_FULL;
                            end
                            else
                            begin
                                edge_we         = 1'b1;
                                edge_total_next = edge_total_reg + EDGE_CW'(1);
                            end
                        end
                    end

                    dgrc_pkg::MODE_TARGET:
                    begin
                        // Fetch the node's count; the check state tests it.
                        node_re    = 1'b1;
                        node_ra    = src_reg[NODE_AW-1:0];
                        state_next = dgrc_pkg::ST_TGT_CHK;
                    end

                    dgrc_pkg::MODE_CULL:
                    begin
                        node_ptr_next = '0;
                        edge_ptr_next = '0;
                        sp_next       = '0;
                        if (node_total_reg == '0)
                        begin
                            state_next = dgrc_pkg::ST_IDLE;
                        end
                        else if (edge_total_reg == '0)
                        begin
                            state_next = dgrc_pkg::ST_SCAN_RD;
                        end
                        else
                        begin
                            state_next = dgrc_pkg::ST_INC_EDGE;
                        end
                    end

                    dgrc_pkg::MODE_CLEAR:
                    begin
                        if (out_free)
                        begin
                            out_load        = 1'b1;
                            node_total_next = '0;
                            edge_total_next = '0;
                            sp_next         = '0;
                            state_next      = dgrc_pkg::ST_IDLE;
                        end
                    end

                    default:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = dgrc_pkg::ST_IDLE;
                        end
                    end
                endcase
            end

            dgrc_pkg::ST_TGT_CHK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = dgrc_pkg::ST_IDLE;
                    if (src_bad)
                    begin
                        status_next = dgrc_pkg::STATUS_BAD_INDEX;
                    end
                    else if (refs_rd_reg != '0)
                    begin
                        status_next = dgrc_pkg::STATUS_CONFLICT;
                    end
                    else
                    begin
                        node_wa = src_reg[NODE_AW-1:0];
                        pin_we  = 1'b1;
                        pin_wd  = 1'b1;
                    end
                end
            end

            // Count pass: one reference for the source of every edge.
            dgrc_pkg::ST_INC_EDGE:
            begin
                edge_re    = 1'b1;
                state_next = dgrc_pkg::ST_INC_NODE;
            end

            dgrc_pkg::ST_INC_NODE:
            begin
                node_re    = 1'b1;
                node_ra    = esrc_rd_reg;
                state_next = dgrc_pkg::ST_INC_WR;
            end

            dgrc_pkg::ST_INC_WR:
            begin
                refs_we = 1'b1;
                refs_wd = (refs_rd_reg == dgrc_pkg::REF_MAX) ? refs_rd_reg
                        : refs_rd_reg + dgrc_pkg::REF_W'(1);
                edge_ptr_next = edge_ptr_reg + EDGE_AW'(1);
                if (last_edge)
                begin
                    state_next = dgrc_pkg::ST_SCAN_RD;
                end
                else
                begin
                    state_next = dgrc_pkg::ST_INC_EDGE;
                end
            end

            // Seed the work stack with every node whose effective count is zero.
            dgrc_pkg::ST_SCAN_RD:
            begin
                node_re    = 1'b1;
                state_next = dgrc_pkg::ST_SCAN_CHK;
            end

            dgrc_pkg::ST_SCAN_CHK:
            begin
                if (!pin_rd_reg && refs_rd_reg == '0 && sp_reg != NODE_CW'(MAX_NODES))
                begin
                    stack_we = 1'b1;
                    sp_next  = sp_reg + NODE_CW'(1);
                end
                node_ptr_next = node_ptr_reg + NODE_AW'(1);
                if (last_node)
                begin
                    state_next = dgrc_pkg::ST_POP;
                end
                else
                begin
                    state_next = dgrc_pkg::ST_SCAN_RD;
                end
            end

            // Pop one dead node and release the sources of its incoming edges.
            dgrc_pkg::ST_POP:
            begin
                edge_ptr_next = '0;
                node_ptr_next = '0;
                if (sp_reg == '0)
                begin
                    state_next = dgrc_pkg::ST_RPT_RD;
                end
                else
                begin
                    stack_re = 1'b1;
                    sp_next  = sp_dec;
                    if (edge_total_reg == '0)
                    begin
                        state_next = dgrc_pkg::ST_POP;
                    end
                    else
                    begin
                        state_next = dgrc_pkg::ST_EDGE_RD;
                    end
                end
            end

            dgrc_pkg::ST_EDGE_RD:
            begin
                edge_re    = 1'b1;
                state_next = dgrc_pkg::ST_EDGE_CHK;
            end

            dgrc_pkg::ST_EDGE_CHK:
            begin
                if (edst_rd_reg == stack_rd_reg)
                begin
                    node_re    = 1'b1;
                    node_ra    = esrc_rd_reg;
                    state_next = dgrc_pkg::ST_DEC_WR;
                end
                else
                begin
                    edge_ptr_next = edge_ptr_reg + EDGE_AW'(1);
                    if (last_edge)
                    begin
                        state_next = dgrc_pkg::ST_POP;
                    end
                    else
                    begin
                        state_next = dgrc_pkg::ST_EDGE_RD;
                    end
                end
            end

            dgrc_pkg::ST_DEC_WR:
            begin
                if (refs_rd_reg != '0)
                begin
                    refs_we = 1'b1;
                    refs_wd = refs_rd_reg - dgrc_pkg::REF_W'(1);
                    // A source that just lost its final reference dies too, unless it is pinned.
                    if (refs_rd_reg == dgrc_pkg::REF_W'(1) && !pin_rd_reg
                        && sp_reg != NODE_CW'(MAX_NODES))
                    begin
                        stack_we = 1'b1;
                        stack_wd = esrc_rd_reg;
                        sp_next  = sp_reg + NODE_CW'(1);
                    end
                end
                edge_ptr_next = edge_ptr_reg + EDGE_AW'(1);
                if (last_edge)
                begin
                    state_next = dgrc_pkg::ST_POP;
                end
                else
                begin
                    state_next = dgrc_pkg::ST_EDGE_RD;
                end
            end

            // Report every node in id order.
            dgrc_pkg::ST_RPT_RD:
            begin
                node_re    = 1'b1;
                state_next = dgrc_pkg::ST_RPT_OUT;
            end

            dgrc_pkg::ST_RPT_OUT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    node_index_next = dgrc_pkg::NODE_W'(node_ptr_reg);
                    ref_total_next  = eff_count;
                    culled_next     = (eff_count == '0);
                    last_next       = last_node;
                    node_ptr_next   = node_ptr_reg + NODE_AW'(1);
                    if (last_node)
                    begin
                        state_next = dgrc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = dgrc_pkg::ST_RPT_RD;
                    end
                end
            end

            default:
            begin
                state_next = dgrc_pkg::ST_IDLE;
            end
        endcase

        // Output register: a loaded word replaces one that is being taken.
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
            node_index_next = node_index_reg;
            ref_total_next  = ref_total_reg;
            culled_next     = culled_reg;
            status_next     = status_reg;
            last_next       = last_reg;
        end
    end

    assign in_stall   = (state_reg != dgrc_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign node_index = node_index_reg;
    assign ref_total  = ref_total_reg;
    assign culled     = culled_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule
